// File: src/pzb_pkg.sv
// pzb_pkg: shared types and constants of the pixel zoom blit core.
// Used by every module in src; depends on nothing.
`default_nettype none
package pzb_pkg;

    // coordinate width; covers dst origin plus the largest spread times offset
    localparam int CW         = 16;
    localparam int ADDR_W     = 17;
    localparam int VALUE_W    = 8;
    localparam int SPREAD_W   = 6;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;

    // mode register fields
    localparam int MODE_SKIP_BLACK = 6;
    localparam int MODE_SKIP_OTHER = 7;

    // writes made at most per source pixel (count of the final one)
    localparam logic [SPREAD_W-1:0] LAST_WRITE = 6'd63;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_X      = 3'd0,
        REG_SRC_Y      = 3'd1,
        REG_WIN_WIDTH  = 3'd2,
        REG_WIN_HEIGHT = 3'd3,
        REG_DST_X      = 3'd4,
        REG_DST_Y      = 3'd5,
        REG_MODE       = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [8:0] src_x;
        logic [7:0] src_y;
        logic [9:0] win_width;
        logic [8:0] win_height;
        logic [8:0] dst_x;
        logic [7:0] dst_y;
        logic [7:0] mode;
    } cfg_t;

    // one square to draw: clipped column and row counts, start address
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [ADDR_W-1:0]   base_addr;
        logic [SPREAD_W-1:0] n_cols;
        logic [SPREAD_W-1:0] n_rows;
    } cmd_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // command queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic {
        BACK_IDLE = 1'b0,
        BACK_RUN  = 1'b1
    } back_state_t;

endpackage
`default_nettype wire

// File: src/pzb_front.sv
// pzb_front: accepts source pixels, drops the ones not copied and turns the
// rest into clipped square commands. Depends on pzb_pkg.
`default_nettype none
module pzb_front #(
    parameter int FRAME_W    = 512,
    parameter int FRAME_H    = 256,
    parameter int MAX_SPREAD = 8
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  pzb_pkg::cfg_t                cfg,
    input  wire                          push,
    output logic                         full,
    input  wire  [pzb_pkg::VALUE_W-1:0]  pixel_value,
    input  wire  [8:0]                   col,
    input  wire  [7:0]                   row,
    input  pzb_pkg::q_status_t           q_status,
    output logic                         q_push,
    output pzb_pkg::cmd_t                q_cmd
);

    localparam logic [12:0] FW13 = 13'(FRAME_W);
    localparam logic [12:0] FH13 = 13'(FRAME_H);
    localparam logic [pzb_pkg::CW-1:0] FW_C = pzb_pkg::CW'(FRAME_W);
    localparam logic [pzb_pkg::CW-1:0] FH_C = pzb_pkg::CW'(FRAME_H);
    localparam logic [pzb_pkg::ADDR_W-1:0] FW_A = pzb_pkg::ADDR_W'(FRAME_W);
    localparam logic [pzb_pkg::SPREAD_W-1:0] MAX_SP = pzb_pkg::SPREAD_W'(MAX_SPREAD);

    logic                            s1_valid_reg, s1_valid_next;
    logic                            s1_keep_reg;
    logic [pzb_pkg::VALUE_W-1:0]     s1_value_reg;
    logic [pzb_pkg::CW-1:0]          s1_bx_reg, s1_by_reg;
    logic [pzb_pkg::SPREAD_W-1:0]    s1_spread_reg;

    logic                            accept, s1_free;
    logic                            in_win, in_src, copy, keep;
    logic [pzb_pkg::SPREAD_W-1:0]    spread;
    logic [pzb_pkg::CW-1:0]          bx, by;
    logic [pzb_pkg::CW-1:0]          room_x, room_y;
    logic [pzb_pkg::SPREAD_W-1:0]    n_cols, n_rows;

    // stage one frees when empty or when the queue takes its content
    assign s1_free = !s1_valid_reg || !q_status.full;
    assign full    = !s1_free;
    assign accept  = push && s1_free;

    // classify the request against window, source frame and mode
    always_comb
    begin
        in_win = ({1'b0, col} < cfg.win_width) && ({1'b0, row} < cfg.win_height);
        in_src = ((13'(cfg.src_x) + 13'(col)) < FW13)
              && ((13'(cfg.src_y) + 13'(row)) < FH13);
        copy   = (pixel_value == '0) ? !cfg.mode[pzb_pkg::MODE_SKIP_BLACK]
                                     : !cfg.mode[pzb_pkg::MODE_SKIP_OTHER];
        keep   = in_win && in_src && copy;

        spread = cfg.mode[pzb_pkg::SPREAD_W-1:0];
        if (spread == '0)
        begin
            spread = pzb_pkg::SPREAD_W'(1);
        end
        if (spread > MAX_SP)
        begin
            spread = MAX_SP;
        end

        bx = pzb_pkg::CW'(cfg.dst_x)
           + pzb_pkg::CW'(15'(spread) * 15'(col));
        by = pzb_pkg::CW'(cfg.dst_y)
           + pzb_pkg::CW'(14'(spread) * 14'(row));
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_free)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // hold the classified pixel and its square origin
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_keep_reg   <= keep;
            s1_value_reg  <= pixel_value;
            s1_bx_reg     <= bx;
            s1_by_reg     <= by;
            s1_spread_reg <= spread;
        end
    end

    // clip the square to the destination frame and form its start address
    always_comb
    begin
        room_x = FW_C - s1_bx_reg;
        room_y = FH_C - s1_by_reg;
        if (s1_bx_reg >= FW_C)
        begin
            n_cols = '0;
        end
        else if (room_x < pzb_pkg::CW'(s1_spread_reg))
        begin
            n_cols = pzb_pkg::SPREAD_W'(room_x);
        end
        else
        begin
            n_cols = s1_spread_reg;
        end
        if (s1_by_reg >= FH_C)
        begin
            n_rows = '0;
        end
        else if (room_y < pzb_pkg::CW'(s1_spread_reg))
        begin
            n_rows = pzb_pkg::SPREAD_W'(room_y);
        end
        else
        begin
            n_rows = s1_spread_reg;
        end

        q_cmd.value     = s1_value_reg;
        q_cmd.base_addr = pzb_pkg::ADDR_W'(pzb_pkg::ADDR_W'(s1_by_reg) * FW_A)
                        + pzb_pkg::ADDR_W'(s1_bx_reg);
        q_cmd.n_cols    = n_cols;
        q_cmd.n_rows    = n_rows;

        // drop requests with nothing inside the frame
        q_push = s1_valid_reg && s1_keep_reg && !q_status.full
              && (n_cols != '0) && (n_rows != '0);
    end

endmodule
`default_nettype wire

// File: src/pzb_queue.sv
// pzb_queue: short command queue between the front and the back end.
// Depends on pzb_pkg.
`default_nettype none
module pzb_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 wr_en,
    input  pzb_pkg::cmd_t       wr_data,
    input  wire                 rd_en,
    output pzb_pkg::cmd_t       rd_data,
    output pzb_pkg::q_status_t  status
);

    localparam logic [pzb_pkg::QPTR_W:0] DEPTH_C = (pzb_pkg::QPTR_W + 1)'(pzb_pkg::QUEUE_DEPTH);

    pzb_pkg::cmd_t                 mem [pzb_pkg::QUEUE_DEPTH];
    logic [pzb_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [pzb_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [pzb_pkg::QPTR_W:0]      count_reg, count_next;

    assign status.full  = (count_reg == DEPTH_C);
    assign status.empty = (count_reg == '0);
    assign rd_data      = mem[rd_ptr_reg];

    // advance pointers and count on push and pop
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the command
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// File: src/pzb_back.sv
// pzb_back: walks each clipped square row by row and emits one frame-buffer
// write per cycle into the free or popped result register. Depends on pzb_pkg.
`default_nettype none
module pzb_back #(
    parameter int FRAME_W = 512
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  pzb_pkg::q_status_t           q_status,
    input  pzb_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    output logic                         empty,
    input  wire                          pop,
    output logic [pzb_pkg::ADDR_W-1:0]   write_address,
    output logic [pzb_pkg::VALUE_W-1:0]  write_value,
    output logic                         last
);

    localparam logic [pzb_pkg::ADDR_W-1:0] FW_A = pzb_pkg::ADDR_W'(FRAME_W);

    pzb_pkg::back_state_t            state_reg, state_next;
    logic                            out_valid_reg, out_valid_next;
    logic [pzb_pkg::ADDR_W-1:0]      out_addr_reg;
    logic [pzb_pkg::VALUE_W-1:0]     out_value_reg;
    logic                            out_last_reg;

    pzb_pkg::cmd_t                   cmd_reg;
    logic [pzb_pkg::ADDR_W-1:0]      row_addr_reg, row_addr_next;
    logic [pzb_pkg::SPREAD_W-1:0]    col_reg, col_next;
    logic [pzb_pkg::SPREAD_W-1:0]    row_reg, row_next;
    logic [pzb_pkg::SPREAD_W-1:0]    cnt_reg, cnt_next;

    logic                            emit, load, end_col, cur_last;

    assign empty         = !out_valid_reg;
    assign write_address = out_addr_reg;
    assign write_value   = out_value_reg;
    assign last          = out_last_reg;

    // walk the square; pick up the next command on the final write
    always_comb
    begin
        end_col  = (col_reg == cmd_reg.n_cols - 1'b1);
        cur_last = (end_col && (row_reg == cmd_reg.n_rows - 1'b1))
                || (cnt_reg == pzb_pkg::LAST_WRITE);
        emit     = (state_reg == pzb_pkg::BACK_RUN) && (!out_valid_reg || pop);

        state_next     = state_reg;
        row_addr_next  = row_addr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        load           = 1'b0;

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pzb_pkg::BACK_IDLE:
            begin
                load = !q_status.empty;
            end
            pzb_pkg::BACK_RUN:
            begin
                if (emit)
                begin
                    if (cur_last)
                    begin
                        load       = !q_status.empty;
                        state_next = pzb_pkg::BACK_IDLE;
                    end
                    else if (end_col)
                    begin
                        col_next      = '0;
                        row_next      = row_reg + 1'b1;
                        row_addr_next = row_addr_reg + FW_A;
                        cnt_next      = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = pzb_pkg::BACK_IDLE;
            end
        endcase

        if (load)
        begin
            state_next    = pzb_pkg::BACK_RUN;
            row_addr_next = q_cmd.base_addr;
            col_next      = '0;
            row_next      = '0;
            cnt_next      = '0;
        end
        q_pop = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pzb_pkg::BACK_IDLE;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
        end
    end

    // hold the current command and the result payload
    always_ff @(posedge clk)
    begin
        row_addr_reg <= row_addr_next;
        if (load)
        begin
            cmd_reg <= q_cmd;
        end
        if (emit)
        begin
            out_addr_reg  <= row_addr_reg + pzb_pkg::ADDR_W'(col_reg);
            out_value_reg <= cmd_reg.value;
            out_last_reg  <= cur_last;
        end
    end

endmodule
`default_nettype wire

// File: src/pixel_zoom_blit_core.sv
// pixel_zoom_blit_core: top level of the nearest-neighbor zoom blitter; holds
// the configuration registers. Depends on pzb_pkg, pzb_front, pzb_queue, pzb_back.
`default_nettype none
// Each source pixel pushed in becomes a spread x spread square of frame-buffer
// writes, clipped to the FRAME_W x FRAME_H frame and cut after 64 writes, sent
// row by row with last set on the final one. A pixel is classified as it is
// accepted, then clipped and addressed from one front register, and lands in a
// two-entry command queue; the back end then makes one write per cycle while
// the output register is empty or being popped, and a dropped pixel never
// reaches the queue. The back-end write loop sets the sustained rate. The user
// must write the configuration registers only while no request is in flight;
// the block itself does not enforce this.
module pixel_zoom_blit_core #(
    parameter int FRAME_W    = 512,
    parameter int FRAME_H    = 256,
    parameter int MAX_SPREAD = 8
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_write,
    input  wire  [pzb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [pzb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                              push,
    output logic                             full,
    input  wire  [pzb_pkg::VALUE_W-1:0]      pixel_value,
    input  wire  [8:0]                       col,
    input  wire  [7:0]                       row,
    output logic                             empty,
    input  wire                              pop,
    output logic [pzb_pkg::ADDR_W-1:0]       write_address,
    output logic [pzb_pkg::VALUE_W-1:0]      write_value,
    output logic                             last
);

    // registers after reset: zoom of one, empty window
    localparam pzb_pkg::cfg_t CFG_RESET = '{
        src_x: 9'd0, src_y: 8'd0, win_width: 10'd0, win_height: 9'd0,
        dst_x: 9'd0, dst_y: 8'd0, mode: 8'd1
    };

    pzb_pkg::cfg_t       cfg_reg, cfg_next;
    pzb_pkg::q_status_t  q_status;
    pzb_pkg::cmd_t       q_wr_cmd, q_rd_cmd;
    logic                q_push, q_pop;

    // decode register writes; indexes past the list are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (pzb_pkg::cfg_index_t'(cfg_index))
                pzb_pkg::REG_SRC_X:      cfg_next.src_x      = cfg_data[8:0];
                pzb_pkg::REG_SRC_Y:      cfg_next.src_y      = cfg_data[7:0];
                pzb_pkg::REG_WIN_WIDTH:  cfg_next.win_width  = cfg_data[9:0];
                pzb_pkg::REG_WIN_HEIGHT: cfg_next.win_height = cfg_data[8:0];
                pzb_pkg::REG_DST_X:      cfg_next.dst_x      = cfg_data[8:0];
                pzb_pkg::REG_DST_Y:      cfg_next.dst_y      = cfg_data[7:0];
                pzb_pkg::REG_MODE:       cfg_next.mode       = cfg_data[7:0];
                default:                 cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pzb_front #(
        .FRAME_W    (FRAME_W),
        .FRAME_H    (FRAME_H),
        .MAX_SPREAD (MAX_SPREAD)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .pixel_value (pixel_value),
        .col         (col),
        .row         (row),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_cmd       (q_wr_cmd)
    );

    pzb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_cmd),
        .rd_en   (q_pop),
        .rd_data (q_rd_cmd),
        .status  (q_status)
    );

    pzb_back #(
        .FRAME_W (FRAME_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_cmd         (q_rd_cmd),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .write_address (write_address),
        .write_value   (write_value),
        .last          (last)
    );

endmodule
`default_nettype wire
